### design/cfld_pkg.sv
// shared types, codes and the fault kind decoder for the cell fault latch table
package cfld_pkg;

	// input item modes
	localparam logic [1:0] MODE_SET      = 2'd0;
	localparam logic [1:0] MODE_CLEAR    = 2'd1;
	localparam logic [1:0] MODE_DEBOUNCE = 2'd2;

	// fault kinds
	localparam logic [2:0] KIND_UV    = 3'd0;
	localparam logic [2:0] KIND_OV    = 3'd1;
	localparam logic [2:0] KIND_OT    = 3'd2;
	localparam logic [2:0] KIND_UT    = 3'd3;
	localparam logic [2:0] KIND_DELTA = 3'd4;
	localparam logic [2:0] KIND_COMM  = 3'd5;
	localparam logic [2:0] KIND_LIMIT = 3'd6;

	// per-cell latch bits
	localparam logic [5:0] LB_NONE  = 6'h00;
	localparam logic [5:0] LB_UV    = 6'h01;
	localparam logic [5:0] LB_OV    = 6'h02;
	localparam logic [5:0] LB_OT    = 6'h04;
	localparam logic [5:0] LB_UT    = 6'h08;
	localparam logic [5:0] LB_COMM  = 6'h10;
	localparam logic [5:0] LB_LIMIT = 6'h20;

	// fault categories
	localparam logic [1:0] CAT_VOLT = 2'd0;
	localparam logic [1:0] CAT_TEMP = 2'd1;
	localparam logic [1:0] CAT_LINK = 2'd2;

	// classified operations passed from front to back
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_DEB   = 2'd3;

	// latch change codes
	localparam logic [1:0] CHG_NONE  = 2'd0;
	localparam logic [1:0] CHG_LATCH = 2'd1;
	localparam logic [1:0] CHG_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  cell_monitor;
		logic [3:0]  cell_position;
		logic [2:0]  fault_kind;
		logic [1:0]  severity;
		logic        condition;
		logic [31:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  latch_changed;
		logic [8:0]  voltage_faults;
		logic [8:0]  temperature_faults;
		logic [7:0]  link_faults;
		logic        system_fault;
		logic [1:0]  worst_severity;
		logic [7:0]  cell_latch_total;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        ok;
		logic [3:0]  cell_monitor;
		logic [3:0]  cell_position;
		logic [5:0]  latch_bit;
		logic [1:0]  cat;
		logic        is_ov;
		logic [1:0]  severity;
		logic        condition;
		logic [31:0] timestamp;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  latches;
		logic [7:0]  count;
		logic        uv_valid;
		logic        ov_valid;
		logic [31:0] uv_start;
		logic [31:0] ov_start;
	} row_t;

	typedef struct packed {
		logic       known;
		logic [5:0] latch_bit;
		logic [1:0] cat;
	} kind_info_t;

	// map a fault kind to its latch bit and category
	function automatic kind_info_t kind_map(input logic [2:0] kind);
		kind_info_t info;
		info = '{known: 1'b1, latch_bit: LB_NONE, cat: CAT_VOLT};
		case (kind)
			KIND_UV:    info.latch_bit = LB_UV;
			KIND_OV:    info.latch_bit = LB_OV;
			KIND_OT:    begin info.latch_bit = LB_OT; info.cat = CAT_TEMP; end
			KIND_UT:    begin info.latch_bit = LB_UT; info.cat = CAT_TEMP; end
			KIND_DELTA: info.latch_bit = LB_OV;
			KIND_COMM:  begin info.latch_bit = LB_COMM; info.cat = CAT_LINK; end
			KIND_LIMIT: begin info.latch_bit = LB_LIMIT; info.cat = CAT_TEMP; end
			default:    info.known = 1'b0;
		endcase
		return info;
	endfunction

endpackage

### design/cfld_ram.sv
// generic single-write, single-read memory with registered read data
module cfld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/cfld_fifo.sv
// small register queue with full and empty flags
module cfld_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

### design/cfld_front.sv
// front end: range check and classification of incoming items
module cfld_front import cfld_pkg::*; #(
	parameter int NUM_MONITORS      = 10,
	parameter int CELLS_PER_MONITOR = 16
) (
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     cmd
);

	kind_info_t info;
	logic       ok;

	assign full   = q_full;
	assign q_push = push && !q_full;

	// classify the item into one back-end operation
	always_comb begin
		info = kind_map(item.fault_kind);
		ok   = (5'(item.cell_monitor) < 5'(NUM_MONITORS)) &&
			(5'(item.cell_position) < 5'(CELLS_PER_MONITOR));
		cmd.op            = OP_NONE;
		cmd.ok            = ok;
		cmd.cell_monitor  = item.cell_monitor;
		cmd.cell_position = item.cell_position;
		cmd.latch_bit     = info.latch_bit;
		cmd.cat           = info.cat;
		cmd.is_ov         = (item.fault_kind == KIND_OV);
		cmd.severity      = item.severity;
		cmd.condition     = item.condition;
		cmd.timestamp     = item.timestamp;
		if (ok) begin
			unique case (item.mode)
				MODE_SET: begin
					if (info.known) cmd.op = OP_SET;
				end
				MODE_CLEAR: begin
					if (info.known && item.fault_kind != KIND_DELTA) cmd.op = OP_CLEAR;
				end
				MODE_DEBOUNCE: begin
					if (item.fault_kind == KIND_UV || item.fault_kind == KIND_OV) cmd.op = OP_DEB;
				end
				default: cmd.op = OP_NONE;
			endcase
		end
	end

endmodule

### design/cfld_back.sv
// back end: per-cell read-modify-write of latches, timers and global counters
module cfld_back import cfld_pkg::*; #(
	parameter int NUM_MONITORS      = 10,
	parameter int CELLS_PER_MONITOR = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] grace_time,
	input  logic        cmd_empty,
	output logic        cmd_pop,
	input  cmd_t        cmd,
	input  logic        res_full,
	output logic        res_push,
	output out_item_t   res
);

	localparam int NUM_CELLS = NUM_MONITORS * CELLS_PER_MONITOR;
	localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int VOLT_W    = $clog2(2 * NUM_CELLS + 1);
	localparam int TEMP_W    = $clog2(3 * NUM_CELLS + 1);
	localparam int LINK_W    = $clog2(NUM_CELLS + 1);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                 state_q;
	cmd_t                 cmd_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [NUM_CELLS-1:0] row_valid_q;
	logic [VOLT_W-1:0]    volt_q;
	logic [TEMP_W-1:0]    temp_q;
	logic [LINK_W-1:0]    link_q;
	logic                 flag_q;
	logic [1:0]           worst_q;

	logic [7:0]        head_lin;
	logic [IDX_W-1:0]  head_idx;
	logic              start;
	logic              exec;
	logic              ram_we;
	row_t              rd_row;
	row_t              wr_row;
	logic              row_ok;
	logic [5:0]        cur_lat;
	logic [7:0]        cur_cnt;
	logic              hit;
	logic              tmr_valid;
	logic [31:0]       tmr_start;
	logic [31:0]       elapsed;
	logic              do_set;
	logic              do_clr;
	logic [7:0]        new_cnt;
	logic [VOLT_W-1:0] volt_n;
	logic [TEMP_W-1:0] temp_n;
	logic [LINK_W-1:0] link_n;
	logic              all_zero;
	logic              flag_n;
	logic [1:0]        worst_n;

	// cell index of the queue head
	assign head_lin = {4'b0, cmd.cell_monitor} * 8'(CELLS_PER_MONITOR) +
		{4'b0, cmd.cell_position};
	assign head_idx = head_lin[IDX_W-1:0];

	assign start    = (state_q == ST_IDLE) && !cmd_empty && !res_full;
	assign exec     = (state_q == ST_EXEC);
	assign cmd_pop  = start;
	assign res_push = exec;
	assign ram_we   = exec && cmd_s1.ok;

	cfld_ram #(
		.WIDTH($bits(row_t)),
		.DEPTH(NUM_CELLS)
	) u_cell_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_s1),
		.wdata(wr_row),
		.re   (start),
		.raddr(head_idx),
		.rdata(rd_row)
	);

	// latch decision and new cell row
	always_comb begin
		row_ok    = row_valid_q[idx_s1];
		cur_lat   = row_ok ? rd_row.latches : '0;
		cur_cnt   = row_ok ? rd_row.count : '0;
		hit       = |(cur_lat & cmd_s1.latch_bit);
		tmr_valid = row_ok && (cmd_s1.is_ov ? rd_row.ov_valid : rd_row.uv_valid);
		tmr_start = tmr_valid ? (cmd_s1.is_ov ? rd_row.ov_start : rd_row.uv_start) :
			cmd_s1.timestamp;
		elapsed   = cmd_s1.timestamp - tmr_start;
		do_set    = 1'b0;
		do_clr    = 1'b0;
		unique case (cmd_s1.op)
			OP_SET:   do_set = !hit;
			OP_CLEAR: do_clr = hit;
			OP_DEB: begin
				if (cmd_s1.condition) begin
					do_set = !hit && (elapsed >= {16'b0, grace_time});
				end else begin
					do_clr = hit;
				end
			end
			default: begin
				do_set = 1'b0;
				do_clr = 1'b0;
			end
		endcase
		new_cnt = cur_cnt + {7'b0, do_set};
		wr_row.count = new_cnt;
		if (do_set) begin
			wr_row.latches = cur_lat | cmd_s1.latch_bit;
		end else if (do_clr) begin
			wr_row.latches = cur_lat & ~cmd_s1.latch_bit;
		end else begin
			wr_row.latches = cur_lat;
		end
		wr_row.uv_valid = row_ok && rd_row.uv_valid;
		wr_row.ov_valid = row_ok && rd_row.ov_valid;
		wr_row.uv_start = rd_row.uv_start;
		wr_row.ov_start = rd_row.ov_start;
		// debounce sample arms or stops its timer
		if (cmd_s1.op == OP_DEB) begin
			if (cmd_s1.is_ov) wr_row.ov_valid = cmd_s1.condition;
			else wr_row.uv_valid = cmd_s1.condition;
			if (cmd_s1.condition) begin
				if (cmd_s1.is_ov) wr_row.ov_start = tmr_start;
				else wr_row.uv_start = tmr_start;
			end
		end
	end

	// category counters, system flag and worst severity
	always_comb begin
		volt_n = volt_q;
		temp_n = temp_q;
		link_n = link_q;
		if (do_set) begin
			case (cmd_s1.cat)
				CAT_VOLT: volt_n = volt_q + 1'b1;
				CAT_TEMP: temp_n = temp_q + 1'b1;
				default:  link_n = link_q + 1'b1;
			endcase
		end else if (do_clr) begin
			case (cmd_s1.cat)
				CAT_VOLT: volt_n = volt_q - 1'b1;
				CAT_TEMP: temp_n = temp_q - 1'b1;
				default:  link_n = link_q - 1'b1;
			endcase
		end
		all_zero = (volt_n == '0) && (temp_n == '0) && (link_n == '0);
		flag_n   = flag_q;
		worst_n  = worst_q;
		if (do_set) begin
			flag_n = 1'b1;
			if (cmd_s1.severity > worst_q) worst_n = cmd_s1.severity;
		end else if (do_clr && all_zero) begin
			flag_n  = 1'b0;
			worst_n = 2'd0;
		end
	end

	// result item
	always_comb begin
		res.accepted           = cmd_s1.ok;
		res.latch_changed      = do_set ? CHG_LATCH : (do_clr ? CHG_CLEAR : CHG_NONE);
		res.voltage_faults     = 9'(volt_n);
		res.temperature_faults = 9'(temp_n);
		res.link_faults        = 8'(link_n);
		res.system_fault       = flag_n;
		res.worst_severity     = worst_n;
		res.cell_latch_total   = cmd_s1.ok ? new_cnt : 8'd0;
	end

	// sequencer, row valid bits and global state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			volt_q      <= '0;
			temp_q      <= '0;
			link_q      <= '0;
			flag_q      <= 1'b0;
			worst_q     <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					volt_q  <= volt_n;
					temp_q  <= temp_n;
					link_q  <= link_n;
					flag_q  <= flag_n;
					worst_q <= worst_n;
					if (cmd_s1.ok) begin
						row_valid_q[idx_s1] <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item held during execution
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
			idx_s1 <= head_idx;
		end
	end

endmodule

### design/cell_fault_latch_debounce_unit.sv
// Cell fault latch table: items are accepted into a two-entry queue, executed
// by a read-modify-write of the per-cell memory row, and results leave through
// a two-entry queue. The back end reads and then writes one cell row per item
// and starts the next item only after that write; a held-off result queue
// stalls the input. Reset clears latches, counts and timers through per-cell
// valid bits; grace_time 0.
module cell_fault_latch_debounce_unit import cfld_pkg::*; #(
	parameter int NUM_MONITORS      = 10,
	parameter int CELLS_PER_MONITOR = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] grace_q;
	logic        cmd_q_full;
	logic        cmd_q_push;
	cmd_t        cmd_in;
	logic        cmd_empty;
	logic        cmd_pop;
	cmd_t        cmd_head;
	logic        res_full;
	logic        res_push;
	out_item_t   res_in;

	assign cfg_ready = 1'b1;

	// grace time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			grace_q <= cfg_data;
		end
	end

	cfld_front #(
		.NUM_MONITORS     (NUM_MONITORS),
		.CELLS_PER_MONITOR(CELLS_PER_MONITOR)
	) u_front (
		.push  (push),
		.full  (full),
		.item  (item),
		.q_full(cmd_q_full),
		.q_push(cmd_q_push),
		.cmd   (cmd_in)
	);

	cfld_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_q_push),
		.full  (cmd_q_full),
		.din   (cmd_in),
		.pop   (cmd_pop),
		.empty (cmd_empty),
		.dout  (cmd_head)
	);

	cfld_back #(
		.NUM_MONITORS     (NUM_MONITORS),
		.CELLS_PER_MONITOR(CELLS_PER_MONITOR)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grace_time(grace_q),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_head),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	cfld_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (res_in),
		.pop   (pop),
		.empty (empty),
		.dout  (result)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for the cell fault latch table: directed and random fault events checked in order
module tb_top import cfld_pkg::*; ();

	localparam int MONITORS      = 10;
	localparam int CELLS_PER_MON = 16;
	localparam int CELL_COUNT    = MONITORS * CELLS_PER_MON;
	localparam int STALL_LIMIT   = 4000;
	localparam int LONG_HOLD     = 150;
	localparam int REPORT_MAX    = 10;

	// codes the package leaves unnamed
	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	cell_fault_latch_debounce_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// latch table mirror
	logic [5:0]  cell_flags     [CELL_COUNT];
	logic [7:0]  cell_new_count [CELL_COUNT];
	logic        uv_armed       [CELL_COUNT];
	logic        ov_armed       [CELL_COUNT];
	logic [31:0] uv_since       [CELL_COUNT];
	logic [31:0] ov_since       [CELL_COUNT];
	int unsigned cat_cnt        [3];
	logic        any_fault;
	logic [1:0]  worst_level;
	logic [15:0] grace_setting;

	in_item_t    fault_event_q     [$];
	out_item_t   expected_status_q [$];
	logic [31:0] clock_ms = 32'hFFFF_FF00;
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	logic        event_taken = 1'b0;
	logic        status_taken = 1'b0;
	logic        hold_request = 1'b0;
	int          push_gap = 0, push_quiet = 0;
	int          pop_stall = 0, pop_quiet = 0, hold_left = 0;

	// fault kind to latch bit and category, 0 when the kind is unknown
	function automatic logic kind_decode(input logic [2:0] kind, output logic [5:0] lbit,
			output logic [1:0] lcat);
		lbit = LB_NONE;
		lcat = CAT_VOLT;
		kind_decode = 1'b1;
		case (kind)
			KIND_UV: lbit = LB_UV;
			KIND_OV, KIND_DELTA: lbit = LB_OV;
			KIND_OT: begin lbit = LB_OT; lcat = CAT_TEMP; end
			KIND_UT: begin lbit = LB_UT; lcat = CAT_TEMP; end
			KIND_COMM: begin lbit = LB_COMM; lcat = CAT_LINK; end
			KIND_LIMIT: begin lbit = LB_LIMIT; lcat = CAT_TEMP; end
			default: kind_decode = 1'b0;
		endcase
	endfunction

	// set a latch, counting it when it is new
	function automatic logic [1:0] latch_fault(input int idx, input logic [2:0] kind,
			input logic [1:0] sev);
		logic [5:0] lbit;
		logic [1:0] lcat;
		if (!kind_decode(kind, lbit, lcat) || (cell_flags[idx] & lbit) != LB_NONE)
			return CHG_NONE;
		cell_flags[idx] = cell_flags[idx] | lbit;
		cat_cnt[lcat]++;
		cell_new_count[idx] = cell_new_count[idx] + 8'd1;
		if (sev > worst_level) worst_level = sev;
		any_fault = 1'b1;
		return CHG_LATCH;
	endfunction

	// clear a latch; the last one drops the system flag and severity
	function automatic logic [1:0] unlatch_fault(input int idx, input logic [2:0] kind);
		logic [5:0] lbit;
		logic [1:0] lcat;
		if (kind == KIND_DELTA || !kind_decode(kind, lbit, lcat) ||
				(cell_flags[idx] & lbit) == LB_NONE)
			return CHG_NONE;
		cell_flags[idx] = cell_flags[idx] & ~lbit;
		if (cat_cnt[lcat] > 0) cat_cnt[lcat]--;
		if (cat_cnt[CAT_VOLT] + cat_cnt[CAT_TEMP] + cat_cnt[CAT_LINK] == 0) begin
			any_fault = 1'b0;
			worst_level = 2'd0;
		end
		return CHG_CLEAR;
	endfunction

	// apply one fault event to the mirror and return the status it should produce
	function automatic out_item_t predict_latch_status(input in_item_t ev);
		out_item_t   st;
		int          idx;
		logic [1:0]  chg;
		logic        in_range;
		logic        is_ov;
		logic [31:0] held;
		in_range = ev.cell_monitor < MONITORS && ev.cell_position < CELLS_PER_MON;
		idx = ev.cell_monitor * CELLS_PER_MON + ev.cell_position;
		chg = CHG_NONE;
		if (in_range) begin
			case (ev.mode)
				MODE_SET: chg = latch_fault(idx, ev.fault_kind, ev.severity);
				MODE_CLEAR: chg = unlatch_fault(idx, ev.fault_kind);
				MODE_DEBOUNCE: begin
					if (ev.fault_kind == KIND_UV || ev.fault_kind == KIND_OV) begin
						is_ov = ev.fault_kind == KIND_OV;
						if (ev.condition) begin
							// timer starts on the first true sample
							if (is_ov && !ov_armed[idx]) begin
								ov_armed[idx] = 1'b1;
								ov_since[idx] = ev.timestamp;
							end
							if (!is_ov && !uv_armed[idx]) begin
								uv_armed[idx] = 1'b1;
								uv_since[idx] = ev.timestamp;
							end
							held = ev.timestamp - (is_ov ? ov_since[idx] : uv_since[idx]);
							if (held >= {16'h0, grace_setting})
								chg = latch_fault(idx, ev.fault_kind, ev.severity);
						end else begin
							if (is_ov) begin
								ov_armed[idx] = 1'b0;
								ov_since[idx] = '0;
							end else begin
								uv_armed[idx] = 1'b0;
								uv_since[idx] = '0;
							end
							chg = unlatch_fault(idx, ev.fault_kind);
						end
					end
				end
				default: chg = CHG_NONE;
			endcase
		end
		st.accepted = in_range;
		st.latch_changed = chg;
		st.voltage_faults = 9'(cat_cnt[CAT_VOLT]);
		st.temperature_faults = 9'(cat_cnt[CAT_TEMP]);
		st.link_faults = 8'(cat_cnt[CAT_LINK]);
		st.system_fault = any_fault;
		st.worst_severity = worst_level;
		st.cell_latch_total = '0;
		if (in_range) st.cell_latch_total = cell_new_count[idx];
		return st;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	task automatic queue_event(input logic [1:0] mode, input int mon, input int pos,
			input logic [2:0] kind, input int sev, input logic cond, input logic [31:0] ts);
		in_item_t ev;
		ev.mode = mode;
		ev.cell_monitor = 4'(mon);
		ev.cell_position = 4'(pos);
		ev.fault_kind = kind;
		ev.severity = 2'(sev);
		ev.condition = cond;
		ev.timestamp = ts;
		fault_event_q.push_back(ev);
	endtask

	// debounce runs, set/clear traffic on a few hot cells, and some noise
	task automatic queue_random_events(input int count, input int step_max);
		int         made, cell_no, run, pick;
		int         hot [8];
		logic [2:0] kind;
		in_item_t   ev;
		foreach (hot[i]) hot[i] = $urandom_range(CELL_COUNT - 1);
		hot[0] = CELL_COUNT - 1;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			cell_no = hot[$urandom_range(7)];
			if (pick < 45) begin
				kind = $urandom_range(1) ? KIND_OV : KIND_UV;
				run = $urandom_range(6, 2);
				repeat (run) begin
					clock_ms += $urandom_range(step_max);
					queue_event(MODE_DEBOUNCE, cell_no / CELLS_PER_MON, cell_no % CELLS_PER_MON,
						kind, $urandom_range(3), 1'b1, clock_ms);
				end
				made += run;
				if ($urandom_range(9) < 6) begin
					clock_ms += $urandom_range(step_max);
					queue_event(MODE_DEBOUNCE, cell_no / CELLS_PER_MON, cell_no % CELLS_PER_MON,
						kind, $urandom_range(3), 1'b0, clock_ms);
					made++;
				end
			end else if (pick < 80) begin
				clock_ms += $urandom_range(step_max);
				queue_event(($urandom_range(9) < 6) ? MODE_SET : MODE_CLEAR,
					cell_no / CELLS_PER_MON, cell_no % CELLS_PER_MON, 3'($urandom_range(6)),
					$urandom_range(3), 1'($urandom_range(1)), clock_ms);
				made++;
			end else begin
				ev = in_item_t'(48'({$urandom(), $urandom()}));
				ev.mode = 2'($urandom_range(3));
				ev.timestamp = $urandom();
				fault_event_q.push_back(ev);
				if (ev.cell_monitor < MONITORS && ev.mode != MODE_SPARE) made++;
			end
		end
	endtask

	// wait until every item is through, then let the pipeline settle
	task automatic drain_pipeline();
		while (fault_event_q.size() != 0 || expected_status_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_grace(input logic [15:0] ms);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= ms;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		grace_setting = ms;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// item driver
	always @(negedge clk) begin
		if (event_taken) begin
			event_taken = 1'b0;
			if (push_quiet > 0) begin
				push_quiet--;
				push_gap = 0;
			end else begin
				push_gap = pick_gap();
				if ($urandom_range(39) == 0) push_quiet = 30;
			end
		end
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push_gap > 0) begin
			push_gap--;
			push <= 1'b0;
		end else if (fault_event_q.size() > 0) begin
			push <= 1'b1;
			item <= fault_event_q[0];
		end else begin
			push <= 1'b0;
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (status_taken) begin
			status_taken = 1'b0;
			if (pop_quiet > 0) begin
				pop_quiet--;
				pop_stall = 0;
			end else begin
				pop_stall = pick_gap();
				if ($urandom_range(39) == 0) pop_quiet = 30;
			end
		end
		if (hold_request && hold_left == 0) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (pop_stall > 0) begin
			pop_stall--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// accept monitor, result checker and watchdog
	always @(posedge clk) begin
		out_item_t want;
		string     bad;
		logic      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				expected_status_q.push_back(predict_latch_status(item));
				void'(fault_event_q.pop_front());
				event_taken = 1'b1;
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				status_taken = 1'b1;
				if (expected_status_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: result with nothing expected: %h", $realtime, result);
				end else begin
					want = expected_status_q.pop_front();
					bad = "";
					if (result.accepted !== want.accepted) bad = {bad, " accepted"};
					if (result.latch_changed !== want.latch_changed) bad = {bad, " latch_changed"};
					if (result.voltage_faults !== want.voltage_faults) bad = {bad, " voltage"};
					if (result.temperature_faults !== want.temperature_faults)
						bad = {bad, " temperature"};
					if (result.link_faults !== want.link_faults) bad = {bad, " link"};
					if (result.system_fault !== want.system_fault) bad = {bad, " system_fault"};
					if (result.worst_severity !== want.worst_severity) bad = {bad, " severity"};
					if (result.cell_latch_total !== want.cell_latch_total) bad = {bad, " total"};
					if (bad != "") begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX) begin
							$display("%0t: mismatch in%s", $realtime, bad);
							$display("  expected acc=%0d chg=%0d v=%0d t=%0d l=%0d sys=%0d sev=%0d tot=%0d",
								want.accepted, want.latch_changed, want.voltage_faults,
								want.temperature_faults, want.link_faults, want.system_fault,
								want.worst_severity, want.cell_latch_total);
							$display("  actual   acc=%0d chg=%0d v=%0d t=%0d l=%0d sys=%0d sev=%0d tot=%0d",
								result.accepted, result.latch_changed, result.voltage_faults,
								result.temperature_faults, result.link_faults, result.system_fault,
								result.worst_severity, result.cell_latch_total);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) moved = 1'b1;
			if (moved) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("cell_fault_latch_debounce_unit verification failed");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		int g;
		for (int i = 0; i < CELL_COUNT; i++) begin
			cell_flags[i] = LB_NONE;
			cell_new_count[i] = '0;
			uv_armed[i] = 1'b0;
			ov_armed[i] = 1'b0;
			uv_since[i] = '0;
			ov_since[i] = '0;
		end
		foreach (cat_cnt[i]) cat_cnt[i] = 0;
		any_fault = 1'b0;
		worst_level = 2'd0;
		grace_setting = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed events with the reset grace time
		queue_event(MODE_SET, 0, 0, KIND_UV, 1, 1'b0, 32'h0000_0000);
		queue_event(MODE_SET, 0, 0, KIND_UV, 2, 1'b0, 32'h0000_0001);
		queue_event(MODE_SET, 9, 15, KIND_OV, 3, 1'b1, 32'hFFFF_FFFF);
		// delta shares the over-voltage latch
		queue_event(MODE_SET, 9, 15, KIND_DELTA, 0, 1'b0, 32'h0000_0010);
		queue_event(MODE_SET, 1, 2, KIND_DELTA, 2, 1'b0, 32'h0000_0020);
		queue_event(MODE_CLEAR, 1, 2, KIND_DELTA, 0, 1'b0, 32'h0000_0021);
		queue_event(MODE_SET, 2, 3, KIND_OT, 0, 1'b0, 32'h0000_0030);
		queue_event(MODE_SET, 2, 3, KIND_UT, 1, 1'b1, 32'h0000_0031);
		queue_event(MODE_SET, 2, 3, KIND_COMM, 2, 1'b0, 32'h0000_0032);
		queue_event(MODE_SET, 2, 3, KIND_LIMIT, 0, 1'b0, 32'h0000_0033);
		queue_event(MODE_SET, 2, 3, KIND_UNUSED, 3, 1'b0, 32'h0000_0034);
		queue_event(MODE_CLEAR, 2, 3, KIND_UNUSED, 3, 1'b0, 32'h0000_0035);
		// out of range chip numbers, spare mode, non-voltage debounce and repeated clears
		queue_event(MODE_SET, 10, 0, KIND_OT, 3, 1'b0, 32'h8000_0000);
		queue_event(MODE_CLEAR, 15, 15, KIND_UV, 3, 1'b1, 32'h7FFF_FFFF);
		queue_event(MODE_SPARE, 3, 4, KIND_UV, 1, 1'b1, 32'h0000_0040);
		queue_event(MODE_DEBOUNCE, 3, 4, KIND_OT, 3, 1'b1, 32'h0000_0041);
		queue_event(MODE_DEBOUNCE, 4, 5, KIND_UV, 2, 1'b1, 32'h0000_0100);
		queue_event(MODE_DEBOUNCE, 4, 5, KIND_UV, 2, 1'b0, 32'h0000_0101);
		queue_event(MODE_CLEAR, 2, 3, KIND_COMM, 0, 1'b0, 32'h0000_0110);
		queue_event(MODE_CLEAR, 2, 3, KIND_COMM, 0, 1'b0, 32'h0000_0111);
		// clear everything left so the system flag drops
		queue_event(MODE_CLEAR, 0, 0, KIND_UV, 0, 1'b0, 32'h0000_0120);
		queue_event(MODE_CLEAR, 9, 15, KIND_OV, 0, 1'b0, 32'h0000_0121);
		queue_event(MODE_CLEAR, 1, 2, KIND_OV, 0, 1'b0, 32'h0000_0122);
		queue_event(MODE_CLEAR, 2, 3, KIND_OT, 0, 1'b0, 32'h0000_0123);
		queue_event(MODE_CLEAR, 2, 3, KIND_UT, 0, 1'b0, 32'h0000_0124);
		queue_event(MODE_CLEAR, 2, 3, KIND_LIMIT, 0, 1'b0, 32'h0000_0125);
		drain_pipeline();

		set_grace(16'd20);
		queue_random_events(170, 12);
		drain_pipeline();

		set_grace(16'hFFFF);
		queue_random_events(110, 45000);
		drain_pipeline();

		// receiver holds off while the sender keeps offering
		set_grace(16'd0);
		hold_request = 1'b1;
		queue_random_events(130, 200000);
		drain_pipeline();

		g = $urandom_range(65534, 1);
		set_grace(16'(g));
		queue_random_events(90, g * 2 / 3 + 3);
		drain_pipeline();

		if (mismatch_count == 0)
			$display("cell_fault_latch_debounce_unit verification clean");
		else
			$display("cell_fault_latch_debounce_unit verification failed");
		$finish;
	end

endmodule
